### rtl/core/tli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and constants of the trajectory linear interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

  // joint count and field widths
  localparam int unsigned JOINTS    = 6;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned STEP_W    = 20;
  localparam logic [STEP_W-1:0] STEP_RESET = 20'd20000;

  // config port geometry
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  // register select bit: clear selects time_step, set is beyond the list
  localparam int unsigned REG_SEL_BIT = 2;

  // quotient bits of the rounding divide (quotient stays below 2^33)
  localparam int unsigned QUO_W     = 33;
  localparam int unsigned CNT_W     = 6;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_START,
    S_WAIT,
    S_PUSH
  } ctrl_state_e;

  // lane states
  typedef enum logic [2:0] {
    L_IDLE,
    L_RDA,
    L_RDB,
    L_MUL,
    L_ADD,
    L_DIV,
    L_FIN,
    L_DONE
  } lane_state_e;

  // command from the sequencer to every lane
  typedef struct packed {
    logic              start;
    logic              interp;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] span;
  } lane_cmd_t;

  // result push from the sequencer to the output stage
  typedef struct packed {
    logic push;
    logic done;
  } push_t;

endpackage

### rtl/core/tli_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_req_if
// Request channel: trajectory point loads and playback ticks.
// ----------------------------------------------------------------------------
interface tli_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic        start_new;
  logic        last_point;
  logic [31:0] point_time;
  logic signed [31:0] joint_pos_1;
  logic signed [31:0] joint_pos_2;
  logic signed [31:0] joint_pos_3;
  logic signed [31:0] joint_pos_4;
  logic signed [31:0] joint_pos_5;
  logic signed [31:0] joint_pos_6;

  modport source (
    output valid, req_type, start_new, last_point, point_time,
           joint_pos_1, joint_pos_2, joint_pos_3, joint_pos_4, joint_pos_5, joint_pos_6,
    input  ready
  );

  modport sink (
    input  valid, req_type, start_new, last_point, point_time,
           joint_pos_1, joint_pos_2, joint_pos_3, joint_pos_4, joint_pos_5, joint_pos_6,
    output ready
  );
endinterface

### rtl/core/tli_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_rsp_if
// Result channel: interpolated joint targets and the done mark.
// ----------------------------------------------------------------------------
interface tli_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] target_1;
  logic signed [31:0] target_2;
  logic signed [31:0] target_3;
  logic signed [31:0] target_4;
  logic signed [31:0] target_5;
  logic signed [31:0] target_6;
  logic        trajectory_done;

  modport source (
    output valid, target_1, target_2, target_3, target_4, target_5, target_6,
           trajectory_done,
    input  ready
  );

  modport sink (
    input  valid, target_1, target_2, target_3, target_4, target_5, target_6,
           trajectory_done,
    output ready
  );
endinterface

### rtl/core/tli_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_lane
// One joint lane: position store plus multiply and serial rounding divide.
// ----------------------------------------------------------------------------
module tli_lane #(
  parameter int unsigned MAX_POINTS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // point store write
  input  logic                                wr_en_i,
  input  logic [$clog2(MAX_POINTS)-1:0]       wr_idx_i,
  input  logic [tli_pkg::POS_W-1:0]           wr_data_i,
  // sample command
  input  tli_pkg::lane_cmd_t                  cmd_i,
  input  logic [$clog2(MAX_POINTS)-1:0]       idx_a_i,
  input  logic [$clog2(MAX_POINTS)-1:0]       idx_b_i,
  output logic                                done_o,
  output logic [tli_pkg::POS_W-1:0]           res_o
);

  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned PW = tli_pkg::POS_W;
  localparam int unsigned TW = tli_pkg::TIME_W;
  localparam int unsigned QW = tli_pkg::QUO_W;

  tli_pkg::lane_state_e state_q, state_d;

  logic [PW-1:0]              mem_q [MAX_POINTS];
  logic [PW-1:0]              rdata_q;
  logic [IW-1:0]              rd_addr;
  logic [PW-1:0]              a_q, res_q;
  logic [PW-1:0]              mag_q;
  logic                       neg_q;
  logic [PW+TW-1:0]           prod_q;
  logic [TW-1:0]              rem_q;
  logic [QW-1:0]              dv_q;
  logic [tli_pkg::CNT_W-1:0]  cnt_q;

  logic [PW:0]                diff, neg_diff;
  logic [PW+TW:0]             nsum;
  logic [TW:0]                trial, trial_sub;
  logic                       ge;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tli_pkg::L_IDLE: if (cmd_i.start) state_d = tli_pkg::L_RDA;
      tli_pkg::L_RDA:  state_d = tli_pkg::L_RDB;
      tli_pkg::L_RDB:  state_d = cmd_i.interp ? tli_pkg::L_MUL : tli_pkg::L_DONE;
      tli_pkg::L_MUL:  state_d = tli_pkg::L_ADD;
      tli_pkg::L_ADD:  state_d = tli_pkg::L_DIV;
      tli_pkg::L_DIV:  if (cnt_q == tli_pkg::DIV_LAST) state_d = tli_pkg::L_FIN;
      tli_pkg::L_FIN:  state_d = tli_pkg::L_DONE;
      tli_pkg::L_DONE: state_d = tli_pkg::L_IDLE;
      default:         state_d = tli_pkg::L_IDLE;
    endcase
  end

  // outputs and read address
  always_comb begin
    rd_addr = (state_q == tli_pkg::L_IDLE) ? idx_a_i : idx_b_i;
    done_o  = (state_q == tli_pkg::L_DONE);
    res_o   = res_q;
  end

  // difference magnitude, rounding bias and one restoring divide step
  always_comb begin
    diff      = {rdata_q[PW-1], rdata_q} - {a_q[PW-1], a_q};
    neg_diff  = -diff;
    nsum      = {1'b0, prod_q} + (PW+TW+1)'(cmd_i.span >> 1);
    trial     = {rem_q, dv_q[QW-1]};
    trial_sub = trial - {1'b0, cmd_i.span};
    ge        = (trial >= {1'b0, cmd_i.span});
  end

  // position store
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      tli_pkg::L_RDA: a_q <= rdata_q;
      tli_pkg::L_RDB: begin
        res_q <= rdata_q;
        neg_q <= diff[PW];
        mag_q <= diff[PW] ? neg_diff[PW-1:0] : diff[PW-1:0];
      end
      tli_pkg::L_MUL: prod_q <= mag_q * cmd_i.num;
      tli_pkg::L_ADD: begin
        rem_q <= nsum[PW+TW -: TW];
        dv_q  <= nsum[QW-1:0];
        cnt_q <= '0;
      end
      tli_pkg::L_DIV: begin
        rem_q <= ge ? trial_sub[TW-1:0] : trial[TW-1:0];
        dv_q  <= {dv_q[QW-2:0], ge};
        cnt_q <= cnt_q + tli_pkg::CNT_W'(1);
      end
      tli_pkg::L_FIN: res_q <= neg_q ? a_q - dv_q[PW-1:0] : a_q + dv_q[PW-1:0];
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tli_pkg::L_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/tli_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_ctrl
// Sequencer: point table bookkeeping, segment search and playback timing.
// ----------------------------------------------------------------------------
module tli_ctrl #(
  parameter int unsigned MAX_POINTS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request handshake and control fields
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic                                start_new_i,
  input  logic                                last_point_i,
  input  logic [tli_pkg::TIME_W-1:0]          point_time_i,
  input  logic [tli_pkg::STEP_W-1:0]          time_step_i,
  // lane control
  output logic                                wr_en_o,
  output logic [$clog2(MAX_POINTS)-1:0]       wr_idx_o,
  output tli_pkg::lane_cmd_t                  cmd_o,
  output logic [$clog2(MAX_POINTS)-1:0]       idx_a_o,
  output logic [$clog2(MAX_POINTS)-1:0]       idx_b_o,
  input  logic                                lanes_done_i,
  // output stage
  input  logic                                out_free_i,
  output tli_pkg::push_t                      push_o
);

  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned TW = tli_pkg::TIME_W;
  localparam logic [CW-1:0] FULL = CW'(MAX_POINTS);

  tli_pkg::ctrl_state_e state_q, state_d;

  logic [CW-1:0] count_q;
  logic [TW-1:0] play_q, last_time_q, t_q, prev_q, num_q, span_q, trd_q;
  logic          playing_q, second_q, interp_q;
  logic [IW-1:0] k_q, ia_q, ib_q;
  logic [TW-1:0] tmem_q [MAX_POINTS];

  logic          accept, is_tick, tick_run;
  logic [CW-1:0] count_eff;
  logic          hit, at_last;
  logic [TW:0]   next_sum;
  logic [TW-1:0] next_play;

  // request decode and helper values
  always_comb begin
    accept    = in_valid_i && (state_q == tli_pkg::S_IDLE);
    is_tick   = req_type_i;
    tick_run  = playing_q && (count_q != '0);
    count_eff = start_new_i ? '0 : count_q;
    hit       = (t_q <= trd_q);
    at_last   = ((CW'(k_q) + CW'(1)) == count_q);
    next_sum  = {1'b0, play_q} + (TW+1)'(time_step_i);
    next_play = next_sum[TW] ? '1 : next_sum[TW-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tli_pkg::S_IDLE:  if (accept && is_tick && tick_run) state_d = tli_pkg::S_SCAN;
      tli_pkg::S_SCAN:  state_d = tli_pkg::S_CMP;
      tli_pkg::S_CMP:   state_d = (hit || at_last) ? tli_pkg::S_START : tli_pkg::S_SCAN;
      tli_pkg::S_START: state_d = tli_pkg::S_WAIT;
      tli_pkg::S_WAIT:  if (lanes_done_i) state_d = tli_pkg::S_PUSH;
      tli_pkg::S_PUSH: begin
        if (out_free_i) begin
          if (!second_q && (next_play >= last_time_q)) state_d = tli_pkg::S_SCAN;
          else                                         state_d = tli_pkg::S_IDLE;
        end
      end
      default:          state_d = tli_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o   = (state_q == tli_pkg::S_IDLE);
    wr_en_o      = accept && !is_tick && (count_eff < FULL);
    wr_idx_o     = count_eff[IW-1:0];
    cmd_o.start  = (state_q == tli_pkg::S_START);
    cmd_o.interp = interp_q;
    cmd_o.num    = num_q;
    cmd_o.span   = span_q;
    idx_a_o      = ia_q;
    idx_b_o      = ib_q;
    push_o.push  = (state_q == tli_pkg::S_PUSH) && out_free_i;
    push_o.done  = second_q;
  end

  // point time store, read at the scan index
  always_ff @(posedge clk_i) begin
    if (wr_en_o) begin
      tmem_q[wr_idx_o] <= point_time_i;
    end
    trd_q <= tmem_q[k_q];
  end

  // search and segment registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      tli_pkg::S_IDLE: begin
        t_q <= play_q;
        k_q <= '0;
      end
      tli_pkg::S_CMP: begin
        if (hit) begin
          ib_q <= k_q;
          ia_q <= k_q - IW'(1);
          num_q  <= t_q - prev_q;
          span_q <= trd_q - prev_q;
          // before the first point, or a non-increasing span, takes the point itself
          interp_q <= (k_q != '0) && (trd_q > prev_q);
        end else if (at_last) begin
          ib_q     <= k_q;
          interp_q <= 1'b0;
        end else begin
          prev_q <= trd_q;
          k_q    <= k_q + IW'(1);
        end
      end
      tli_pkg::S_PUSH: begin
        // second sample is taken at the last point's time
        t_q <= last_time_q;
        k_q <= '0;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tli_pkg::S_IDLE;
      count_q     <= '0;
      play_q      <= '0;
      last_time_q <= '0;
      playing_q   <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && !is_tick) begin
        if (start_new_i) begin
          play_q <= '0;
        end
        if (count_eff < FULL) begin
          count_q     <= count_eff + CW'(1);
          last_time_q <= point_time_i;
        end else begin
          count_q <= count_eff;
        end
        // last point arms, a fresh start alone disarms
        if (last_point_i) begin
          playing_q <= 1'b1;
        end else if (start_new_i) begin
          playing_q <= 1'b0;
        end
      end
      if (accept && is_tick) second_q <= 1'b0;
      if (push_o.push) begin
        if (second_q) begin
          playing_q <= 1'b0;
          second_q  <= 1'b0;
        end else begin
          play_q <= next_play;
          if (next_play >= last_time_q) second_q <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/tli_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_merge
// Merging stage: gathers the lane results into the output register.
// ----------------------------------------------------------------------------
module tli_merge (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tli_pkg::push_t             push_i,
  input  logic [tli_pkg::POS_W-1:0]  lane_res_i [tli_pkg::JOINTS],
  output logic                       free_o,
  tli_rsp_if.source                  rsp_o
);

  logic                      valid_q;
  logic                      done_q;
  logic [tli_pkg::POS_W-1:0] tgt_q [tli_pkg::JOINTS];

  // slot is free when empty or being drained this cycle
  assign free_o = !valid_q || rsp_o.ready;

  // output payload
  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      tgt_q  <= lane_res_i;
      done_q <= push_i.done;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i.push) begin
      valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  assign rsp_o.valid           = valid_q;
  assign rsp_o.target_1        = tgt_q[0];
  assign rsp_o.target_2        = tgt_q[1];
  assign rsp_o.target_3        = tgt_q[2];
  assign rsp_o.target_4        = tgt_q[3];
  assign rsp_o.target_5        = tgt_q[4];
  assign rsp_o.target_6        = tgt_q[5];
  assign rsp_o.trajectory_done = done_q;

endmodule

### rtl/core/trajectory_linear_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trajectory_linear_interpolator
// Piecewise linear playback of a stored joint trajectory, one lane per joint.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries load items (req_type 0) that append a trajectory point and
//   tick items (req_type 1) that sample the trajectory at the playback time.
//   rsp_o carries six joint targets and trajectory_done. The APB port holds
//   time_step, the playback time added per tick.
//   A load is stored as it is taken. A tick while playback is not armed is
//   taken and gives no item. An armed tick runs a sample: the sequencer scans
//   the point time store one point at a time (up to MAX_POINTS points), then
//   the six lanes run together: for an interpolated segment they read both
//   points, do one 32x32 multiply, add the rounding bias and run a 33-step
//   serial divide; for a held point they only read the point. A push state
//   follows, and the next request is taken once the sequencer is back in
//   idle. A tick that finishes playback runs a second sample for the done
//   item.
//   One output register parts the two sides: new requests are taken while a
//   finished item waits; a stalled receiver holds the next sample only at its
//   push. Reset empties the table, disarms playback and sets time_step to
//   20000. The point stores are not cleared; only written entries are read.
// ----------------------------------------------------------------------------
module trajectory_linear_interpolator #(
  parameter int unsigned MAX_POINTS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tli_req_if.sink                       req_i,
  tli_rsp_if.source                     rsp_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tli_pkg::PADDR_W-1:0]   paddr,
  input  logic [tli_pkg::PDATA_W-1:0]   pwdata,
  output logic [tli_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned NJ = tli_pkg::JOINTS;

  logic [tli_pkg::STEP_W-1:0] step_q;
  logic                       cfg_wr;

  logic                       wr_en;
  logic [IW-1:0]              wr_idx, idx_a, idx_b;
  tli_pkg::lane_cmd_t         cmd;
  tli_pkg::push_t             push;
  logic [NJ-1:0]              lane_done;
  logic                       out_free;
  logic [tli_pkg::POS_W-1:0]  in_pos   [NJ];
  logic [tli_pkg::POS_W-1:0]  lane_res [NJ];

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[tli_pkg::REG_SEL_BIT];
  assign prdata = paddr[tli_pkg::REG_SEL_BIT] ? '0 :
                  tli_pkg::PDATA_W'(step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= tli_pkg::STEP_RESET;
    end else if (cfg_wr) begin
      step_q <= pwdata[tli_pkg::STEP_W-1:0];
    end
  end

  // joint positions of the request item
  assign in_pos[0] = req_i.joint_pos_1;
  assign in_pos[1] = req_i.joint_pos_2;
  assign in_pos[2] = req_i.joint_pos_3;
  assign in_pos[3] = req_i.joint_pos_4;
  assign in_pos[4] = req_i.joint_pos_5;
  assign in_pos[5] = req_i.joint_pos_6;

  // sequencer
  tli_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_i.valid),
    .in_ready_o   (req_i.ready),
    .req_type_i   (req_i.req_type),
    .start_new_i  (req_i.start_new),
    .last_point_i (req_i.last_point),
    .point_time_i (req_i.point_time),
    .time_step_i  (step_q),
    .wr_en_o      (wr_en),
    .wr_idx_o     (wr_idx),
    .cmd_o        (cmd),
    .idx_a_o      (idx_a),
    .idx_b_o      (idx_b),
    .lanes_done_i (&lane_done),
    .out_free_i   (out_free),
    .push_o       (push)
  );

  // one lane per joint
  for (genvar j = 0; j < NJ; j++) begin : g_lane
    tli_lane #(
      .MAX_POINTS (MAX_POINTS)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (wr_en),
      .wr_idx_i  (wr_idx),
      .wr_data_i (in_pos[j]),
      .cmd_i     (cmd),
      .idx_a_i   (idx_a),
      .idx_b_i   (idx_b),
      .done_o    (lane_done[j]),
      .res_o     (lane_res[j])
    );
  end

  // output register
  tli_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .lane_res_i (lane_res),
    .free_o     (out_free),
    .rsp_o      (rsp_o)
  );

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks trajectory_linear_interpolator against its own predictor of point
// loading and playback. Directed loads and ticks come first, then random
// trajectories under several time_step settings with random gaps on both
// channels, a long receiver stall, and a long segment at the largest step.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_POINTS    = 32;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 300;
  localparam int MAX_PRINTED   = 100;

  // register addresses
  localparam logic [tli_pkg::PADDR_W-1:0] ADDR_TIME_STEP = tli_pkg::PADDR_W'(0);
  localparam logic [tli_pkg::PADDR_W-1:0] ADDR_NO_REG    =
    tli_pkg::PADDR_W'(1 << tli_pkg::REG_SEL_BIT);

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_TICK = 1'b1
  } req_kind_e;

  typedef logic [tli_pkg::JOINTS-1:0][tli_pkg::POS_W-1:0] joints_t;

  typedef struct packed {
    req_kind_e                  kind;
    logic                       start_new;
    logic                       last_point;
    logic [tli_pkg::TIME_W-1:0] point_time;
    joints_t                    pos;
  } traj_req_t;

  typedef struct packed {
    joints_t tgt;
    logic    done;
  } traj_target_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [tli_pkg::PADDR_W-1:0] paddr;
  logic [tli_pkg::PDATA_W-1:0] pwdata;
  logic [tli_pkg::PDATA_W-1:0] prdata;
  logic pready;

  tli_req_if req_if ();
  tli_rsp_if rsp_if ();

  trajectory_linear_interpolator #(
    .MAX_POINTS(MAX_POINTS)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // predicted block state
  logic [tli_pkg::TIME_W-1:0] traj_times [MAX_POINTS];
  joints_t                    traj_pos [MAX_POINTS];
  int                         traj_count = 0;
  logic [tli_pkg::TIME_W-1:0] play_time = '0;
  bit                         play_armed = 1'b0;
  logic [tli_pkg::STEP_W-1:0] step_us = tli_pkg::STEP_RESET;

  traj_target_t pending_targets [$];
  int err_count = 0;
  int items_counted = 0;
  int max_gap = 6;
  int rsp_hold_cycles = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_error(input string msg);
    if (err_count < MAX_PRINTED) begin
      $display("[%0t] ERROR: %s", $time, msg);
    end
    err_count++;
  endtask

  // one joint between two points, quotient rounded half away from zero
  function automatic logic [tli_pkg::POS_W-1:0] lerp_joint(
      input logic signed [tli_pkg::POS_W-1:0] pa,
      input logic signed [tli_pkg::POS_W-1:0] pb,
      input logic [tli_pkg::TIME_W-1:0] num,
      input logic [tli_pkg::TIME_W-1:0] span);
    longint a;
    longint b;
    longint d;
    longint unsigned mag;
    longint unsigned quo;
    a = pa;
    b = pb;
    d = b - a;
    mag = (d < 0) ? longint'(-d) : d;
    quo = (mag * {32'd0, num} + {33'd0, span[tli_pkg::TIME_W-1:1]}) / {32'd0, span};
    return (d < 0) ? tli_pkg::POS_W'(a - longint'(quo)) : tli_pkg::POS_W'(a + longint'(quo));
  endfunction

  // joint targets at playback time t
  function automatic joints_t sample_trajectory(input logic [tli_pkg::TIME_W-1:0] t);
    joints_t res;
    res = traj_pos[traj_count-1];
    if (t <= traj_times[0]) return traj_pos[0];
    for (int k = 1; k < traj_count; k++) begin
      if (t <= traj_times[k]) begin
        for (int j = 0; j < tli_pkg::JOINTS; j++) begin
          if (traj_times[k] > traj_times[k-1]) begin
            res[j] = lerp_joint(traj_pos[k-1][j], traj_pos[k][j], t - traj_times[k-1],
                                traj_times[k] - traj_times[k-1]);
          end else begin
            res[j] = traj_pos[k][j];
          end
        end
        return res;
      end
    end
    return res;
  endfunction

  // update predicted state for one accepted item, queue its results
  function automatic bit apply_request(input traj_req_t it);
    traj_target_t r;
    logic [tli_pkg::TIME_W:0] next_t;
    bit counts;
    counts = 1'b0;
    if (it.kind == REQ_LOAD) begin
      if (it.start_new) begin
        traj_count = 0;
        play_time = '0;
        play_armed = 1'b0;
      end
      if (traj_count < MAX_POINTS) begin
        traj_times[traj_count] = it.point_time;
        traj_pos[traj_count] = it.pos;
        traj_count++;
        counts = 1'b1;
      end
      if (it.last_point && traj_count > 0) play_armed = 1'b1;
      return counts;
    end
    if (!play_armed || traj_count == 0) return 1'b0;
    r.tgt = sample_trajectory(play_time);
    r.done = 1'b0;
    pending_targets = {pending_targets, r};
    next_t = {1'b0, play_time} + (tli_pkg::TIME_W + 1)'(step_us);
    play_time = next_t[tli_pkg::TIME_W] ? '1 : next_t[tli_pkg::TIME_W-1:0];
    if (play_time >= traj_times[traj_count-1]) begin
      r.tgt = sample_trajectory(traj_times[traj_count-1]);
      r.done = 1'b1;
      pending_targets = {pending_targets, r};
      play_armed = 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic joints_t rand_joints();
    joints_t p;
    for (int j = 0; j < tli_pkg::JOINTS; j++) begin
      case ($urandom_range(0, 7))
        0: p[j] = 32'h8000_0000;
        1: p[j] = 32'h7fff_ffff;
        default: p[j] = $urandom;
      endcase
    end
    return p;
  endfunction

  function automatic traj_req_t random_item(input req_kind_e kind);
    traj_req_t it;
    it.kind = kind;
    it.start_new = 1'($urandom);
    it.last_point = 1'($urandom);
    it.point_time = $urandom;
    it.pos = rand_joints();
    return it;
  endfunction

  function automatic traj_req_t load_item(input logic start, input logic last,
                                          input logic [tli_pkg::TIME_W-1:0] t,
                                          input joints_t pos);
    traj_req_t it;
    it.kind = REQ_LOAD;
    it.start_new = start;
    it.last_point = last;
    it.point_time = t;
    it.pos = pos;
    return it;
  endfunction

  // drive one item after a random gap, predict at acceptance
  task automatic send_request(input traj_req_t it);
    int gap;
    gap = $urandom_range(0, max_gap);
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.req_type = it.kind;
    req_if.start_new = it.start_new;
    req_if.last_point = it.last_point;
    req_if.point_time = it.point_time;
    req_if.joint_pos_1 = it.pos[0];
    req_if.joint_pos_2 = it.pos[1];
    req_if.joint_pos_3 = it.pos[2];
    req_if.joint_pos_4 = it.pos[3];
    req_if.joint_pos_5 = it.pos[4];
    req_if.joint_pos_6 = it.pos[5];
    req_if.valid = 1'b1;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    if (apply_request(it)) items_counted++;
  endtask

  // stop sending, wait for every expected item, then let the block go quiet
  task automatic settle();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (pending_targets.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [tli_pkg::PADDR_W-1:0] addr,
                           input logic [tli_pkg::PDATA_W-1:0] data);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (addr == ADDR_TIME_STEP) step_us = data[tli_pkg::STEP_W-1:0];
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // one trajectory with random content, then ticks, appends and re-arms
  task automatic run_trajectory(input bit arm);
    traj_req_t it;
    int n;
    int cap;
    logic [tli_pkg::TIME_W-1:0] t;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_POINTS - 2, MAX_POINTS + 4)
                                    : $urandom_range(1, 6);
    t = ($urandom_range(0, 3) == 0) ? '0 : tli_pkg::TIME_W'($urandom_range(0, 3 * step_us));
    for (int i = 0; i < n; i++) begin
      it = random_item(REQ_LOAD);
      it.start_new = (i == 0);
      it.last_point = arm && (i == n - 1);
      // now and then a point earlier than the one before
      it.point_time = ($urandom_range(0, 19) == 0) ? tli_pkg::TIME_W'($urandom_range(0, t)) : t;
      send_request(it);
      if ($urandom_range(0, 5) != 0) begin
        t = t + tli_pkg::TIME_W'($urandom_range(0, 2 * step_us + 2));
      end
    end
    if (!arm) repeat (2) send_request(random_item(REQ_TICK));
    cap = n + 8;
    for (int i = 0; i < cap; i++) begin
      if (!play_armed && $urandom_range(0, 4) != 0) break;
      if (!play_armed || $urandom_range(0, 9) == 0) begin
        it = random_item(REQ_LOAD);
        it.start_new = 1'b0;
        it.last_point = !play_armed || ($urandom_range(0, 1) == 1);
        it.point_time = t;
        t = t + tli_pkg::TIME_W'(step_us);
      end else begin
        it = random_item(REQ_TICK);
      end
      send_request(it);
    end
  endtask

  // directed corner cases at the reset time_step
  task automatic test_directed();
    joints_t lo;
    joints_t hi;
    joints_t mix;
    lo = {tli_pkg::JOINTS{32'h8000_0000}};
    hi = {tli_pkg::JOINTS{32'h7fff_ffff}};
    mix = {32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0001, 32'h0};
    // address past the register list is ignored
    write_reg(ADDR_NO_REG, $urandom);
    // tick with an empty table
    send_request(random_item(REQ_TICK));
    // full-scale swing, zero span at the end
    send_request(load_item(1'b1, 1'b0, 32'd1000, lo));
    send_request(load_item(1'b0, 1'b0, 32'd50000, hi));
    send_request(load_item(1'b0, 1'b1, 32'd50000, mix));
    repeat (4) send_request(random_item(REQ_TICK));
    // append after finish with an earlier time, re-arms
    send_request(load_item(1'b0, 1'b1, 32'd0, hi ^ mix));
    send_request(random_item(REQ_TICK));
    // points at the largest time
    send_request(load_item(1'b1, 1'b0, 32'hffff_ffff, rand_joints()));
    send_request(load_item(1'b0, 1'b1, 32'hffff_ffff, rand_joints()));
    repeat (2) send_request(random_item(REQ_TICK));
    // single point trajectory
    send_request(load_item(1'b1, 1'b1, 32'd0, mix));
    send_request(random_item(REQ_TICK));
    // append while armed
    send_request(load_item(1'b1, 1'b0, 32'd0, lo));
    send_request(load_item(1'b0, 1'b1, 32'd40000, hi));
    send_request(random_item(REQ_TICK));
    send_request(load_item(1'b0, 1'b0, 32'd60000, mix));
    repeat (3) send_request(random_item(REQ_TICK));
  endtask

  // loads past the table size are dropped, the last flag still arms
  task automatic test_table_full();
    logic [tli_pkg::TIME_W-1:0] t;
    int guard;
    t = '0;
    for (int i = 0; i < MAX_POINTS + 2; i++) begin
      send_request(load_item(i == 0, i == MAX_POINTS + 1, t, rand_joints()));
      t = t + tli_pkg::TIME_W'($urandom_range(0, 30000));
    end
    guard = 0;
    while (play_armed && guard < 200) begin
      send_request(random_item(REQ_TICK));
      guard++;
    end
  endtask

  // receiver holds off while ticks keep coming, so the input stalls
  task automatic test_backpressure();
    settle();
    write_reg(ADDR_TIME_STEP, tli_pkg::PDATA_W'(1000));
    max_gap = 0;
    send_request(load_item(1'b1, 1'b0, 32'd0, rand_joints()));
    send_request(load_item(1'b0, 1'b0, 32'd50000, rand_joints()));
    send_request(load_item(1'b0, 1'b1, 32'd100000, rand_joints()));
    rsp_hold_cycles = 400;
    repeat (30) send_request(random_item(REQ_TICK));
    max_gap = 6;
    settle();
  endtask

  task automatic test_random_playback(input logic [tli_pkg::STEP_W-1:0] step,
                                      input int n_items);
    int stop_at;
    traj_req_t it;
    settle();
    write_reg(ADDR_TIME_STEP, tli_pkg::PDATA_W'(step));
    stop_at = items_counted + n_items;
    while (items_counted < stop_at) begin
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
      case ($urandom_range(0, 9))
        0: begin
          it = random_item(REQ_TICK);
          it.kind = req_kind_e'($urandom_range(0, 1));
          send_request(it);
        end
        1: run_trajectory(1'b0);
        default: run_trajectory(1'b1);
      endcase
    end
    max_gap = 6;
  endtask

  // largest step across one long segment, wide products in every lane
  task automatic test_long_segment();
    int guard;
    settle();
    write_reg(ADDR_TIME_STEP, tli_pkg::PDATA_W'({tli_pkg::STEP_W{1'b1}}));
    max_gap = 0;
    send_request(load_item(1'b1, 1'b0, 32'd0, rand_joints()));
    send_request(load_item(1'b0, 1'b1, 32'h03c0_0000, rand_joints()));
    guard = 0;
    while (play_armed && guard < 200) begin
      send_request(random_item(REQ_TICK));
      guard++;
    end
    max_gap = 6;
  endtask

  // result receiver with random and long stalls
  initial begin : result_sink
    int wait_cycles;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      wait_cycles = $urandom_range(0, max_gap);
      if (rsp_hold_cycles > 0) begin
        wait_cycles = rsp_hold_cycles;
        rsp_hold_cycles = 0;
      end
      if (wait_cycles > 0) begin
        rsp_if.ready = 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      rsp_if.ready = 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
    end
  end

  // compare each accepted result item with the oldest expectation
  always @(posedge clk_i) begin : result_check
    traj_target_t got;
    traj_target_t want;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got.tgt[0] = rsp_if.target_1;
      got.tgt[1] = rsp_if.target_2;
      got.tgt[2] = rsp_if.target_3;
      got.tgt[3] = rsp_if.target_4;
      got.tgt[4] = rsp_if.target_5;
      got.tgt[5] = rsp_if.target_6;
      got.done = rsp_if.trajectory_done;
      if (pending_targets.size() == 0) begin
        report_error("result item with no expectation");
      end else begin
        want = pending_targets.pop_front();
        for (int j = 0; j < tli_pkg::JOINTS; j++) begin
          if (got.tgt[j] !== want.tgt[j]) begin
            report_error($sformatf("target_%0d got %h expected %h", j + 1, got.tgt[j],
                                   want.tgt[j]));
          end
        end
        if (got.done !== want.done) begin
          report_error($sformatf("trajectory_done got %b expected %b", got.done, want.done));
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  // main sequence
  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_LOAD;
    req_if.start_new = 1'b0;
    req_if.last_point = 1'b0;
    req_if.point_time = '0;
    req_if.joint_pos_1 = '0;
    req_if.joint_pos_2 = '0;
    req_if.joint_pos_3 = '0;
    req_if.joint_pos_4 = '0;
    req_if.joint_pos_5 = '0;
    req_if.joint_pos_6 = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_table_full();
    test_backpressure();
    test_random_playback(tli_pkg::STEP_W'(20000), 190);
    test_random_playback(tli_pkg::STEP_W'(1), 190);
    test_random_playback(tli_pkg::STEP_W'(1000000), 190);
    test_random_playback(tli_pkg::STEP_W'(0), 160);
    test_random_playback({tli_pkg::STEP_W{1'b1}}, 190);
    test_random_playback(tli_pkg::STEP_W'($urandom_range(1, 1000000)), 200);
    test_long_segment();
    settle();

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
